@@ design/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the MIDI serial message parser
// Holds the status byte constants and the parsed message bundle that
// travels from the parser core to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam logic [7:0] STATUS_BIT   = 8'h80;
	localparam logic [7:0] LOW_NIBBLE   = 8'h0F;
	localparam logic [7:0] SYSTEM_BASE  = 8'hF0;
	localparam logic [7:0] SYSEX_START  = 8'hF0;

	// One parsed message as it leaves the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] message_type;
		logic [3:0] channel;
		logic [6:0] data_first;
		logic [6:0] data_second;
	} msp_result_t;

endpackage

`default_nettype wire

@@ design/msp_parser.sv @@
// ----------------------------------------------------------------------------
// msp_parser: MIDI byte stream parser core
// Holds the parse phase and the current message header; turns one byte per
// enabled cycle into at most one complete message.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_parser
	import msp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	output msp_result_t      result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_DATA1 = 3'd1,
		PH_DATA2 = 3'd2,
		PH_SYSEX = 3'd3
	} phase_t;

	typedef enum logic [1:0] {
		LEN_NONE = 2'd0,
		LEN_ZERO = 2'd1,
		LEN_ONE  = 2'd2,
		LEN_TWO  = 2'd3
	} msg_len_t;

	// Data bytes that follow a status byte (channel nibble already cleared)
	function automatic msg_len_t data_len(input logic [7:0] mtype);
		msg_len_t len;
		len = LEN_NONE;
		if (mtype < SYSTEM_BASE) begin
			case (mtype[7:4]) inside
				4'hC, 4'hD: len = LEN_ONE;
				default:    len = LEN_TWO;
			endcase
		end else begin
			case (mtype) inside
				8'hF1, 8'hF3:                              len = LEN_ONE;
				8'hF2:                                     len = LEN_TWO;
				8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: len = LEN_ZERO;
				default:                                   len = LEN_NONE;
			endcase
		end
		return len;
	endfunction

	phase_t     phase_q, phase_d;
	logic [7:0] held_type_q, held_type_d;
	logic [3:0] held_channel_q, held_channel_d;
	logic [6:0] held_first_q, held_first_d;
	logic [7:0] status_type;
	msg_len_t   status_len;
	msg_len_t   held_len;

	assign status_type = (rx_byte < SYSTEM_BASE) ? (rx_byte & ~LOW_NIBBLE) : rx_byte;
	assign status_len  = data_len(status_type);
	assign held_len    = data_len(held_type_q);

	// Next state and result for the byte at hand
	always_comb begin
		phase_d        = phase_q;
		held_type_d    = held_type_q;
		held_channel_d = held_channel_q;
		held_first_d   = held_first_q;
		result         = '0;
		if ((rx_byte & STATUS_BIT) != 8'h00) begin
			// status byte: always starts over
			held_type_d    = status_type;
			held_channel_d = rx_byte[3:0];
			if (rx_byte == SYSEX_START) begin
				phase_d = PH_SYSEX;
			end else begin
				case (status_len)
					LEN_ZERO: begin
						phase_d             = PH_IDLE;
						result.valid        = step;
						result.message_type = status_type;
						result.channel      = rx_byte[3:0];
					end
					LEN_ONE, LEN_TWO: phase_d = PH_DATA1;
					default:          phase_d = PH_IDLE;
				endcase
			end
		end else begin
			case (phase_q)
				PH_DATA1: begin
					if (held_len == LEN_ONE) begin
						phase_d             = PH_IDLE;
						result.valid        = step;
						result.message_type = held_type_q;
						result.channel      = held_channel_q;
						result.data_first   = rx_byte[6:0];
					end else begin
						held_first_d = rx_byte[6:0];
						phase_d      = PH_DATA2;
					end
				end
				PH_DATA2: begin
					phase_d             = PH_IDLE;
					result.valid        = step;
					result.message_type = held_type_q;
					result.channel      = held_channel_q;
					result.data_first   = held_first_q;
					result.data_second  = rx_byte[6:0];
				end
				PH_SYSEX: phase_d = PH_SYSEX;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// Parser state, updated only when a byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			held_type_q    <= '0;
			held_channel_q <= '0;
			held_first_q   <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			held_type_q    <= held_type_d;
			held_channel_q <= held_channel_d;
			held_first_q   <= held_first_d;
		end
	end

	// A completed message always drops the parser back to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> phase_q == PH_IDLE)
		else $error("parser not idle after a completed message");

	// Data bytes inside SysEx never produce a message
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYSEX && !rx_byte[7]) |-> !result.valid)
		else $error("message emitted inside SysEx");

	// Every message carries a status byte as its type
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.message_type[7])
		else $error("message type without status bit");

	// Second phase is only reachable for three-byte messages
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA2 |-> held_len == LEN_TWO)
		else $error("waiting on second data byte of a short message");

endmodule

`default_nettype wire

@@ design/msp_out_reg.sv @@
// ----------------------------------------------------------------------------
// msp_out_reg: message output register
// Holds one parsed message on the output channel until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_out_reg
	import msp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire msp_result_t result,
	input  wire logic        out_stall,
	output logic             ready,
	output logic             out_valid,
	output logic [7:0]       message_type,
	output logic [3:0]       channel,
	output logic [6:0]       data_first,
	output logic [6:0]       data_second
);

	logic        valid_q;
	msp_result_t data_q;

	// Free when empty or when the held message leaves this cycle
	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			data_q <= result;
		end
	end

	assign out_valid    = valid_q;
	assign message_type = data_q.message_type;
	assign channel      = data_q.channel;
	assign data_first   = data_q.data_first;
	assign data_second  = data_q.data_second;

endmodule

`default_nettype wire

@@ design/midi_serial_message_parser_top.sv @@
// ----------------------------------------------------------------------------
// midi_serial_message_parser_top: MIDI serial byte stream parser
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received MIDI
//   byte per request. Output channel (out_valid / out_stall and the message
//   fields) carries one complete message per request.
//   A status byte always starts a new message and drops any partial one;
//   single-byte system messages come out at once, others after their one or
//   two data bytes. SysEx content, data bytes while idle, end of exclusive
//   and undefined status bytes produce nothing.
//   A byte taken in passes through the input register, then is parsed into
//   the output register.
//   Throughput: one byte per cycle while the receiver does not stall.
//   When the receiver stalls with a message held, the parser waits on the
//   byte in the input register and in_stall rises; no message is lost.
//   Reset (arst_n low) empties both registers and returns the parser to
//   idle with a cleared message header.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_serial_message_parser_top
	import msp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      message_type,
	output logic [3:0]      channel,
	output logic [6:0]      data_first,
	output logic [6:0]      data_second
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_ready;
	logic        step;
	msp_result_t result;

	// Byte in stage one moves on when the output register has room
	assign step     = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	msp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.result  (result)
	);

	msp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.result       (result),
		.out_stall    (out_stall),
		.ready        (out_ready),
		.out_valid    (out_valid),
		.message_type (message_type),
		.channel      (channel),
		.data_first   (data_first),
		.data_second  (data_second)
	);

endmodule

`default_nettype wire
